/* rtl/core/rdwt_pkg.sv */
// Shared types and constants for the readiness and deadline wait table.
package rdwt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int KEY_W     = 31;
    localparam int EV_W      = 16;
    localparam int DL_W      = 49;
    localparam int NOW_W     = 48;
    localparam logic [EV_W-1:0] ALWAYS_RST = EV_W'(24);

    typedef enum logic [2:0] {
        CMD_ADD         = 3'd0,
        CMD_REMOVE      = 3'd1,
        CMD_MARK_READY  = 3'd2,
        CMD_CLEAR_READY = 3'd3,
        CMD_WAIT        = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_ACK         = 3'd0,
        KIND_FULL        = 3'd1,
        KIND_NOT_FOUND   = 3'd2,
        KIND_READY       = 3'd3,
        KIND_TIMED_OUT   = 3'd4,
        KIND_NOTHING_DUE = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT,
        S_WREADY,
        S_WTIME
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [EV_W-1:0]        interest;
        logic signed [DL_W-1:0] deadline;
        logic [EV_W-1:0]        ready;
    } t_entry;

endpackage

/* rtl/core/rdwt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rdwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/readiness_deadline_wait_table.sv */
// Top level of the readiness and deadline wait table.
//
// Commands enter on start when busy is low: add, remove, mark ready,
// clear_ready and wait, with key, interest, events, deadline and now.
// Results leave on o_strobe, one cycle each; o_last marks the final result
// of a command. The receiver cannot hold results off.
// Entries live in one RAM of SLOTS rows with a registered read port; a
// sequencer walks it one row per cycle, with one read in flight.
// Command flow:
//   add, mark ready, clear_ready: a key scan.
//   remove: key scan, then each later entry is moved down one row.
//   wait: two passes over the table; the second pass
//   compacts survivors while it reports timeouts.
//   unknown command: ack on the next cycle, busy stays low.
// The always_mask register is written on the cfg channel while idle.
// Reset empties the table and sets always_mask to error and hangup; the
// RAM itself needs no clearing pass.
module readiness_deadline_wait_table #(
    parameter int SLOTS = rdwt_pkg::SLOTS_DEF,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_command,
    input  logic [rdwt_pkg::KEY_W-1:0]    i_key,
    input  logic [rdwt_pkg::EV_W-1:0]     i_interest,
    input  logic [rdwt_pkg::EV_W-1:0]     i_events,
    input  logic signed [rdwt_pkg::DL_W-1:0] i_deadline,
    input  logic [rdwt_pkg::NOW_W-1:0]    i_now,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rdwt_pkg::EV_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output logic [2:0]                    o_kind,
    output logic [rdwt_pkg::KEY_W-1:0]    o_out_key,
    output logic [rdwt_pkg::EV_W-1:0]     o_fired_events,
    output logic [CW-1:0]                 o_occupancy,
    output logic                          o_last
);

    import rdwt_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_addr, n_addr;
    logic [CW-1:0]    r_w, n_w;
    logic [CW-1:0]    r_live, n_live;
    logic             r_rd_vld;
    logic [CW-1:0]    r_rd_idx;
    logic [EV_W-1:0]  r_always;

    logic [2:0]             r_cmd;
    logic [KEY_W-1:0]       r_key;
    logic [EV_W-1:0]        r_interest;
    logic [EV_W-1:0]        r_events;
    logic signed [DL_W-1:0] r_deadline;
    logic [NOW_W-1:0]       r_now;

    logic             r_pend_vld, n_pend_vld;
    t_kind            r_pend_kind, n_pend_kind;
    logic [KEY_W-1:0] r_pend_key, n_pend_key;
    logic [EV_W-1:0]  r_pend_ev, n_pend_ev;
    logic [CW-1:0]    r_pend_live, n_pend_live;

    logic             r_out_vld, n_out_vld;
    t_kind            r_out_kind, n_out_kind;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic [EV_W-1:0]  r_out_ev, n_out_ev;
    logic [CW-1:0]    r_out_live, n_out_live;
    logic             r_out_last, n_out_last;

    logic                  accept;
    logic                  issue;
    logic                  we;
    logic [AW-1:0]         waddr;
    t_entry                wdata;
    t_entry                rd;
    logic [$bits(t_entry)-1:0] ram_rdata;
    logic [EV_W-1:0]       hit;
    logic                  key_hit;
    logic                  scan_end;
    logic                  more;
    logic                  due;
    logic [CW-1:0]         idx_dec;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;

    rdwt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd       = t_entry'(ram_rdata);
    assign hit      = rd.ready & (rd.interest | r_always);
    assign key_hit  = r_rd_vld && (rd.key == r_key);
    assign more     = (r_addr < r_count);
    assign scan_end = !r_rd_vld && !more;
    assign due      = !rd.deadline[DL_W-1] && (rd.deadline[NOW_W-1:0] <= r_now);
    assign idx_dec  = r_rd_idx - CW'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_w         = r_w;
        n_live      = r_live;
        n_pend_vld  = r_pend_vld;
        n_pend_kind = r_pend_kind;
        n_pend_key  = r_pend_key;
        n_pend_ev   = r_pend_ev;
        n_pend_live = r_pend_live;
        n_out_vld   = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_key   = r_out_key;
        n_out_ev    = r_out_ev;
        n_out_live  = r_out_live;
        n_out_last  = r_out_last;
        issue       = 1'b0;
        we          = 1'b0;
        waddr       = r_rd_idx[AW-1:0];
        wdata       = rd;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr = '0;
                    case (i_command)
                        CMD_WAIT: begin
                            n_state    = S_WREADY;
                            n_live     = r_count;
                            n_pend_vld = 1'b0;
                        end
                        CMD_ADD, CMD_REMOVE, CMD_MARK_READY, CMD_CLEAR_READY: begin
                            n_state = S_FIND;
                        end
                        default: begin
                            n_out_vld  = 1'b1;
                            n_out_kind = KIND_ACK;
                            n_out_key  = i_key;
                            n_out_ev   = '0;
                            n_out_live = r_count;
                            n_out_last = 1'b1;
                        end
                    endcase
                end
            end

            S_FIND: begin
                n_out_key  = r_key;
                n_out_ev   = '0;
                n_out_last = 1'b1;
                n_out_live = r_count;
                n_out_kind = KIND_ACK;
                if (key_hit) begin
                    case (r_cmd)
                        CMD_REMOVE: begin
                            n_state = S_SHIFT;
                            n_addr  = r_rd_idx + CW'(1);
                        end
                        CMD_ADD: begin
                            we             = 1'b1;
                            wdata.key      = r_key;
                            wdata.interest = r_interest;
                            wdata.deadline = r_deadline;
                            n_out_vld      = 1'b1;
                            n_state        = S_IDLE;
                        end
                        CMD_MARK_READY: begin
                            we          = 1'b1;
                            wdata.ready = rd.ready | r_events;
                            n_out_vld   = 1'b1;
                            n_state     = S_IDLE;
                        end
                        default: begin
                            we          = 1'b1;
                            wdata.ready = '0;
                            n_out_vld   = 1'b1;
                            n_state     = S_IDLE;
                        end
                    endcase
                end else if (scan_end) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (r_cmd == CMD_ADD) begin
                        if (r_count >= SLOTS_C) begin
                            n_out_kind = KIND_FULL;
                        end else begin
                            we             = 1'b1;
                            waddr          = r_count[AW-1:0];
                            wdata.key      = r_key;
                            wdata.interest = r_interest;
                            wdata.deadline = r_deadline;
                            wdata.ready    = '0;
                            n_count        = r_count + CW'(1);
                            n_out_live     = r_count + CW'(1);
                        end
                    end else begin
                        n_out_kind = KIND_NOT_FOUND;
                    end
                end else begin
                    issue = more;
                    if (more) begin
                        n_addr = r_addr + CW'(1);
                    end
                end
            end

            S_SHIFT: begin
                if (r_rd_vld) begin
                    we    = 1'b1;
                    waddr = idx_dec[AW-1:0];
                end
                if (scan_end) begin
                    n_count    = r_count - CW'(1);
                    n_out_vld  = 1'b1;
                    n_out_kind = KIND_ACK;
                    n_out_key  = r_key;
                    n_out_ev   = '0;
                    n_out_live = r_count - CW'(1);
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    issue = more;
                    if (more) begin
                        n_addr = r_addr + CW'(1);
                    end
                end
            end

            S_WREADY: begin
                if (r_rd_vld && (hit != '0)) begin
                    if (r_pend_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_kind = r_pend_kind;
                        n_out_key  = r_pend_key;
                        n_out_ev   = r_pend_ev;
                        n_out_live = r_pend_live;
                        n_out_last = 1'b0;
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_kind = KIND_READY;
                    n_pend_key  = rd.key;
                    n_pend_ev   = hit;
                    n_pend_live = r_live - CW'(1);
                    n_live      = r_live - CW'(1);
                end
                if (scan_end) begin
                    n_state = S_WTIME;
                    n_addr  = '0;
                    n_w     = '0;
                end else begin
                    issue = more;
                    if (more) begin
                        n_addr = r_addr + CW'(1);
                    end
                end
            end

            S_WTIME: begin
                if (r_rd_vld && (hit == '0)) begin
                    if (due) begin
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_kind = r_pend_kind;
                            n_out_key  = r_pend_key;
                            n_out_ev   = r_pend_ev;
                            n_out_live = r_pend_live;
                            n_out_last = 1'b0;
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_kind = KIND_TIMED_OUT;
                        n_pend_key  = rd.key;
                        n_pend_ev   = '0;
                        n_pend_live = r_live - CW'(1);
                        n_live      = r_live - CW'(1);
                    end else begin
                        we    = 1'b1;
                        waddr = r_w[AW-1:0];
                        n_w   = r_w + CW'(1);
                    end
                end
                if (scan_end) begin
                    n_count    = r_w;
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                    if (r_pend_vld) begin
                        n_out_kind = r_pend_kind;
                        n_out_key  = r_pend_key;
                        n_out_ev   = r_pend_ev;
                        n_out_live = r_pend_live;
                    end else begin
                        n_out_kind = KIND_NOTHING_DUE;
                        n_out_key  = '0;
                        n_out_ev   = '0;
                        n_out_live = r_w;
                    end
                end else begin
                    issue = more;
                    if (more) begin
                        n_addr = r_addr + CW'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_always   <= ALWAYS_RST;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_vld   <= issue;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_always <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_w         <= n_w;
        r_live      <= n_live;
        r_rd_idx    <= r_addr;
        r_pend_kind <= n_pend_kind;
        r_pend_key  <= n_pend_key;
        r_pend_ev   <= n_pend_ev;
        r_pend_live <= n_pend_live;
        r_out_kind  <= n_out_kind;
        r_out_key   <= n_out_key;
        r_out_ev    <= n_out_ev;
        r_out_live  <= n_out_live;
        r_out_last  <= n_out_last;
        if (accept) begin
            r_cmd      <= i_command;
            r_key      <= i_key;
            r_interest <= i_interest;
            r_events   <= i_events;
            r_deadline <= i_deadline;
            r_now      <= i_now;
        end
    end

    assign o_strobe       = r_out_vld;
    assign o_kind         = r_out_kind;
    assign o_out_key      = r_out_key;
    assign o_fired_events = r_out_ev;
    assign o_occupancy    = r_out_live;
    assign o_last         = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("entry count beyond table size");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("non-final result with sequencer idle");

    a_ready_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == KIND_READY)) |-> (o_fired_events != '0))
        else $error("ready result without event bits");

    a_quiet_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind != KIND_READY)) |-> (o_fired_events == '0))
        else $error("event bits on a non-ready result");

endmodule
